@@ rtl/mbpne_pkg.sv @@
package mbpne_pkg;

  // note keys and per-key counter store (start counters then stop counters)
  localparam int KEY_COUNT       = 128;
  localparam int KEY_BITS        = $clog2(KEY_COUNT);
  localparam int COUNTER_DEPTH   = 2 * KEY_COUNT;
  localparam int COUNTER_WIDTH   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // status byte codes
  localparam logic [7:0] ST_SYSTEM        = 8'hF0;
  localparam logic [7:0] ST_SYSEX         = 8'hF0;
  localparam logic [7:0] ST_TIME_CODE     = 8'hF1;
  localparam logic [7:0] ST_SONG_POSITION = 8'hF2;
  localparam logic [7:0] ST_SONG_SELECT   = 8'hF3;
  localparam logic [7:0] ST_REALTIME      = 8'hF8;

  // channel message codes, status high nibble minus eight
  localparam logic [2:0] CMD_NOTE_OFF = 3'd0;
  localparam logic [2:0] CMD_NOTE_ON  = 3'd1;
  localparam logic [2:0] CMD_POLY     = 3'd2;
  localparam logic [2:0] CMD_CONTROL  = 3'd3;
  localparam logic [2:0] CMD_PROGRAM  = 3'd4;
  localparam logic [2:0] CMD_PRESSURE = 3'd5;
  localparam logic [2:0] CMD_WHEEL    = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_CHANNEL_MASK = 2'd0;
  localparam logic [1:0] REG_MESSAGE_MASK = 2'd1;
  localparam logic [1:0] REG_INSTRUMENT   = 2'd2;

  localparam logic [15:0] CHANNEL_MASK_RESET = 16'hFFFF;
  localparam logic [7:0]  MESSAGE_MASK_RESET = 8'h07;

  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_STOP    = 2'd1,
    EV_CONTROL = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    SKIP_NONE  = 2'd0,
    SKIP_SYSEX = 2'd1,
    SKIP_COUNT = 2'd2
  } skip_mode_t;

  // one complete, filtered channel message
  typedef struct packed {
    event_kind_t kind;
    logic [2:0]  cmd;
    logic [3:0]  chn;
    logic [6:0]  d1;
    logic [6:0]  d2;
  } mbpne_msg_t;

endpackage

@@ rtl/mbpne_if.sv @@
interface mbpne_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink (input valid, input midi_byte, output ready);
endinterface

interface mbpne_event_if;
  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [3:0]        channel;
  logic [6:0]        key_number;
  logic signed [7:0] pitch;
  logic [6:0]        velocity;
  logic [31:0]       event_id;
  logic [7:0]        message_code;
  logic signed [7:0] control_number;
  logic [6:0]        control_value;
  logic [11:0]       instrument;

  modport source (
    output valid, output event_kind, output channel, output key_number, output pitch,
    output velocity, output event_id, output message_code, output control_number,
    output control_value, output instrument, input ready
  );
  modport sink (
    input valid, input event_kind, input channel, input key_number, input pitch,
    input velocity, input event_id, input message_code, input control_number,
    input control_value, input instrument, output ready
  );
endinterface

@@ rtl/mbpne_ram.sv @@
module mbpne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when it meets a write to the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mbpne_front.sv @@
module mbpne_front import mbpne_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  mbpne_byte_if.sink        rx,
  input  logic [15:0]       channel_enable_mask,
  input  logic [7:0]        message_enable_mask,
  input  logic              queue_full,
  output logic              push,
  output mbpne_msg_t        msg
);

  logic [7:0] running_status, running_status_next;
  logic [6:0] first_data_byte, first_data_byte_next;
  logic       data_bytes_held, data_bytes_held_next;
  skip_mode_t skip_mode, skip_mode_next;
  logic [1:0] skip_remaining, skip_remaining_next;

  logic        take;
  logic [7:0]  b;
  logic [2:0]  cmd_nib;
  logic        need_two;
  logic        complete;
  logic        has_event;
  logic        pass;
  event_kind_t kind;
  logic [6:0]  d1;
  logic [6:0]  d2;

  assign rx.ready = !queue_full;
  assign take     = rx.valid && rx.ready;
  assign b        = rx.midi_byte;
  assign cmd_nib  = running_status[6:4];
  assign need_two = !(cmd_nib == CMD_PROGRAM || cmd_nib == CMD_PRESSURE);

  always_comb begin
    running_status_next  = running_status;
    first_data_byte_next = first_data_byte;
    data_bytes_held_next = data_bytes_held;
    skip_mode_next       = skip_mode;
    skip_remaining_next  = skip_remaining;
    complete             = 1'b0;
    if (take) begin
      if (b[7]) begin
        if (b < ST_SYSTEM) begin
          running_status_next  = b;
          data_bytes_held_next = 1'b0;
          skip_mode_next       = SKIP_NONE;
          skip_remaining_next  = 2'd0;
        end else if (b < ST_REALTIME) begin
          skip_mode_next      = SKIP_NONE;
          skip_remaining_next = 2'd0;
          priority if (b == ST_SYSEX) begin
            skip_mode_next = SKIP_SYSEX;
          end else if (b == ST_TIME_CODE || b == ST_SONG_SELECT) begin
            skip_mode_next      = SKIP_COUNT;
            skip_remaining_next = 2'd1;
          end else if (b == ST_SONG_POSITION) begin
            skip_mode_next      = SKIP_COUNT;
            skip_remaining_next = 2'd2;
          end else begin
            // other system common bytes skip nothing
          end
        end
      end else begin
        unique case (skip_mode)
          SKIP_SYSEX: begin
          end
          SKIP_COUNT: begin
            if (skip_remaining != 2'd0) begin
              skip_remaining_next = skip_remaining - 2'd1;
            end
            if (skip_remaining <= 2'd1) begin
              skip_mode_next = SKIP_NONE;
            end
          end
          default: begin
            if (running_status != 8'd0) begin
              if (need_two && !data_bytes_held) begin
                first_data_byte_next = b[6:0];
                data_bytes_held_next = 1'b1;
              end else begin
                data_bytes_held_next = 1'b0;
                complete             = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  assign d1 = need_two ? first_data_byte : b[6:0];
  assign d2 = need_two ? b[6:0] : 7'd0;

  always_comb begin
    kind      = EV_CONTROL;
    has_event = 1'b1;
    unique case (cmd_nib)
      CMD_NOTE_OFF: kind = EV_STOP;
      CMD_NOTE_ON:  kind = (d2 != 7'd0) ? EV_START : EV_STOP;
      CMD_CONTROL, CMD_PROGRAM, CMD_PRESSURE, CMD_WHEEL: kind = EV_CONTROL;
      default:      has_event = 1'b0;
    endcase
  end

  assign pass = channel_enable_mask[running_status[3:0]] && message_enable_mask[cmd_nib];
  assign push = complete && pass && has_event;

  assign msg.kind = kind;
  assign msg.cmd  = cmd_nib;
  assign msg.chn  = running_status[3:0];
  assign msg.d1   = d1;
  assign msg.d2   = d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status  <= 8'd0;
      first_data_byte <= 7'd0;
      data_bytes_held <= 1'b0;
      skip_mode       <= SKIP_NONE;
      skip_remaining  <= 2'd0;
    end else begin
      running_status  <= running_status_next;
      first_data_byte <= first_data_byte_next;
      data_bytes_held <= data_bytes_held_next;
      skip_mode       <= skip_mode_next;
      skip_remaining  <= skip_remaining_next;
    end
  end

  a_count_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (skip_mode == SKIP_COUNT) |-> (skip_remaining != 2'd0))
    else $error("counted skip with nothing left to skip");

  a_held_needs_status: assert property (@(posedge clk) disable iff (rst)
    data_bytes_held |-> (running_status != 8'd0))
    else $error("data byte held without running status");

endmodule

@@ rtl/mbpne_queue.sv @@
module mbpne_queue import mbpne_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  mbpne_msg_t msg_in,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output mbpne_msg_t msg_out
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mbpne_msg_t     slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign msg_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= msg_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("message queue overrun");

endmodule

@@ rtl/mbpne_back.sv @@
module mbpne_back import mbpne_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  mbpne_msg_t  q_msg,
  output logic        pop,
  input  logic [11:0] instrument_number,
  mbpne_event_if.source tx
);

  localparam int AW = $clog2(COUNTER_DEPTH);

  logic                     s1_valid;
  mbpne_msg_t               s1_msg;
  logic                     advance;
  logic                     s1_load;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            s1_addr;
  logic [COUNTER_DEPTH-1:0] written;
  logic                     written_q;
  logic [COUNTER_WIDTH-1:0] ram_rdata;
  logic                     last_valid;
  logic [AW-1:0]            last_addr;
  logic [COUNTER_WIDTH-1:0] last_count;
  logic [COUNTER_WIDTH-1:0] old_count;
  logic [COUNTER_WIDTH-1:0] new_count;
  logic                     is_note;
  logic                     wr_en;

  // the output register empties or is taken, so stage one may move on
  assign advance = !tx.valid || tx.ready;
  assign s1_load = !s1_valid || advance;
  assign pop     = q_valid && s1_load;

  // stop counters sit in the upper half of the store
  assign rd_addr = {q_msg.kind == EV_STOP, q_msg.d1};
  assign s1_addr = {s1_msg.kind == EV_STOP, s1_msg.d1};

  // the latest write always matches the store, so it covers a read that met it
  always_comb begin
    if (last_valid && last_addr == s1_addr) begin
      old_count = last_count;
    end else if (written_q) begin
      old_count = ram_rdata;
    end else begin
      old_count = '0;
    end
  end

  assign new_count = old_count + COUNTER_WIDTH'(1);
  assign is_note   = (s1_msg.kind != EV_CONTROL);
  assign wr_en     = s1_valid && advance && is_note;

  mbpne_ram #(
    .WIDTH (COUNTER_WIDTH),
    .DEPTH (COUNTER_DEPTH)
  ) u_counters (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (new_count),
    .re    (pop),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      tx.valid   <= 1'b0;
      written    <= '0;
      last_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= q_valid;
      end
      if (advance) begin
        tx.valid <= s1_valid;
      end
      if (wr_en) begin
        written[s1_addr] <= 1'b1;
        last_valid       <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_msg    <= q_msg;
      written_q <= written[rd_addr];
    end
    if (wr_en) begin
      last_addr  <= s1_addr;
      last_count <= new_count;
    end
    if (s1_valid && advance) begin
      tx.event_kind   <= s1_msg.kind;
      tx.channel      <= s1_msg.chn;
      tx.message_code <= {1'b1, s1_msg.cmd, 4'h0};
      tx.instrument   <= instrument_number;
      if (is_note) begin
        tx.key_number     <= s1_msg.d1;
        tx.pitch          <= {1'b0, s1_msg.d1} - 8'd12;
        tx.velocity       <= s1_msg.d2;
        tx.event_id       <= {1'b1, 11'd0, s1_msg.chn, 1'b0, s1_msg.d1, new_count};
        tx.control_number <= 8'hFF;
        tx.control_value  <= 7'd0;
      end else begin
        tx.key_number <= 7'd0;
        tx.pitch      <= 8'sd0;
        tx.velocity   <= 7'd0;
        tx.event_id   <= 32'd0;
        if (s1_msg.cmd == CMD_CONTROL) begin
          tx.control_number <= {1'b0, s1_msg.d1};
          tx.control_value  <= s1_msg.d2;
        end else begin
          tx.control_number <= 8'hFF;
          tx.control_value  <= s1_msg.d1;
        end
      end
    end
  end

  a_note_id_tagged: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.event_kind != EV_CONTROL) |-> tx.event_id[31])
    else $error("note event without id tag");

  a_control_id_zero: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.event_kind == EV_CONTROL) |-> (tx.event_id == 32'd0))
    else $error("control event with nonzero id");

endmodule

@@ rtl/midi_byte_parser_note_events_unit.sv @@
// midi byte parser with note start/stop and control events
//
// rx_bytes takes one raw midi byte per item (valid/ready). status bytes set
// running status or start a sysex / system-common skip; real-time bytes are
// dropped. when a channel message completes and passes the channel and
// message masks and is not poly aftertouch, a message goes into a small queue.
// note_events gives at most one event per byte: note start, note stop (each
// with its per-key 8-bit counter in event_id) or control event.
// throughput: one byte per cycle unless note_events stalls; the counter
// read-modify-write is split across the registered ram read and the output
// stage, with the last write forwarded so back-to-back hits on one key stay
// exact. events go from the queue through stage one to the output register.
// when note_events stalls, the output register and stage one hold, the queue
// fills, and rx_bytes.ready drops only once the queue is full.
// reset clears parsing state, the queue, the pipeline and the per-entry
// written bits, so every counter reads as zero with no clearing pass.
// apb port: 0x0 channel mask, 0x4 message mask, 0x8 instrument number;
// write only while idle
module midi_byte_parser_note_events_unit import mbpne_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mbpne_byte_if.sink    rx_bytes,
  mbpne_event_if.source note_events,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  // configuration registers
  logic [15:0] channel_enable_mask;
  logic [7:0]  message_enable_mask;
  logic [11:0] instrument_number;
  logic        cfg_write;

  // front to queue to back
  logic       push;
  mbpne_msg_t front_msg;
  logic       queue_full;
  logic       pop;
  logic       q_valid;
  mbpne_msg_t q_msg;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable_mask <= CHANNEL_MASK_RESET;
      message_enable_mask <= MESSAGE_MASK_RESET;
      instrument_number   <= 12'd0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_CHANNEL_MASK: channel_enable_mask <= pwdata[15:0];
        REG_MESSAGE_MASK: message_enable_mask <= pwdata[7:0];
        REG_INSTRUMENT:   instrument_number   <= pwdata[11:0];
        default: begin
        end
      endcase
    end
  end

  // register readback, unused addresses read zero
  always_comb begin
    unique case (paddr[3:2])
      REG_CHANNEL_MASK: prdata = {16'd0, channel_enable_mask};
      REG_MESSAGE_MASK: prdata = {24'd0, message_enable_mask};
      REG_INSTRUMENT:   prdata = {20'd0, instrument_number};
      default:          prdata = 32'd0;
    endcase
  end

  // parses bytes, filters and classifies complete messages
  mbpne_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .rx                  (rx_bytes),
    .channel_enable_mask (channel_enable_mask),
    .message_enable_mask (message_enable_mask),
    .queue_full          (queue_full),
    .push                (push),
    .msg                 (front_msg)
  );

  // decouples parsing from counter updates and output stalls
  mbpne_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .msg_in  (front_msg),
    .full    (queue_full),
    .pop     (pop),
    .valid   (q_valid),
    .msg_out (q_msg)
  );

  // bumps per-key counters and builds the output events
  mbpne_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_msg             (q_msg),
    .pop               (pop),
    .instrument_number (instrument_number),
    .tx                (note_events)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import mbpne_pkg::*;

  // run limit in clock cycles, far above the slowest correct run
  localparam int CYCLE_LIMIT = 400000;
  // cycles to let the pipeline settle once nothing is expected
  localparam int SETTLE_CYCLES = 8;
  // longest wait for outstanding events before giving up on them
  localparam int DRAIN_LIMIT = 5000;

  // one expected note or control event
  typedef struct {
    event_kind_t       kind;
    logic [3:0]        channel;
    logic [6:0]        key_number;
    logic signed [7:0] pitch;
    logic [6:0]        velocity;
    logic [31:0]       event_id;
    logic [7:0]        message_code;
    logic signed [7:0] control_number;
    logic [6:0]        control_value;
    logic [11:0]       instrument;
  } note_event_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mbpne_byte_if  rx_if ();
  mbpne_event_if ev_if ();

  midi_byte_parser_note_events_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .rx_bytes    (rx_if),
    .note_events (ev_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // bookkeeping shared by the stimulus and the checker
  note_event_t pending_events[$];
  int          cycles = 0;
  int          errors = 0;
  bit          no_idle = 1'b0;

  // parser state as the block should hold it
  logic [7:0]  cur_status;
  logic [6:0]  held_first;
  logic [1:0]  held_count;
  skip_mode_t  skip_kind;
  logic [1:0]  skip_left;
  logic [7:0]  start_count[KEY_COUNT];
  logic [7:0]  stop_count[KEY_COUNT];

  // register copies as the block should hold them
  logic [15:0] chan_enable;
  logic [7:0]  msg_enable;
  logic [11:0] instr_reg;

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog, ends a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still expected", cycles,
               pending_events.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one line per mismatch, each one counted
  task automatic report(input string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic void reset_parser_copy();
    chan_enable = CHANNEL_MASK_RESET;
    msg_enable  = MESSAGE_MASK_RESET;
    instr_reg   = '0;
    cur_status  = '0;
    held_first  = '0;
    held_count  = '0;
    skip_kind   = SKIP_NONE;
    skip_left   = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      start_count[k] = '0;
      stop_count[k]  = '0;
    end
  endfunction

  // a complete channel message: filter, bump counters, queue the event
  function automatic void complete_message(input logic [6:0] d1, input logic [6:0] d2);
    logic [2:0]  cmd;
    logic [3:0]  chn;
    logic [7:0]  cnt;
    note_event_t ev;
    cmd = cur_status[6:4];
    chn = cur_status[3:0];
    if (!chan_enable[chn] || !msg_enable[cmd]) return;
    ev.channel      = chn;
    ev.message_code = {1'b1, cmd, 4'b0000};
    ev.instrument   = instr_reg;
    if (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON) begin
      if (cmd == CMD_NOTE_ON && d2 != 7'd0) begin
        start_count[d1] = start_count[d1] + 8'd1;
        cnt = start_count[d1];
        ev.kind = EV_START;
      end else begin
        // note off, or note on with zero velocity
        stop_count[d1] = stop_count[d1] + 8'd1;
        cnt = stop_count[d1];
        ev.kind = EV_STOP;
      end
      ev.key_number     = d1;
      ev.pitch          = {1'b0, d1} - 8'd12;
      ev.velocity       = d2;
      ev.event_id       = {1'b1, 11'd0, chn, 1'b0, d1, cnt};
      ev.control_number = -8'sd1;
      ev.control_value  = '0;
      pending_events.push_back(ev);
    end else if (cmd == CMD_CONTROL || cmd == CMD_PROGRAM || cmd == CMD_PRESSURE ||
                 cmd == CMD_WHEEL) begin
      ev.kind       = EV_CONTROL;
      ev.key_number = '0;
      ev.pitch      = '0;
      ev.velocity   = '0;
      ev.event_id   = '0;
      if (cmd == CMD_CONTROL) begin
        ev.control_number = {1'b0, d1};
        ev.control_value  = d2;
      end else begin
        ev.control_number = -8'sd1;
        ev.control_value  = d1;
      end
      pending_events.push_back(ev);
    end
    // polyphonic aftertouch gives nothing
  endfunction

  // one accepted byte through the parser copy
  function automatic void predict_byte(input logic [7:0] b);
    logic [2:0] cmd;
    bit         two_bytes;
    if (b[7]) begin
      if (b < ST_SYSTEM) begin
        cur_status = b;
        held_count = '0;
        skip_kind  = SKIP_NONE;
        skip_left  = '0;
      end else if (b < ST_REALTIME) begin
        // system common and sysex; running status and held data stay
        skip_kind = SKIP_NONE;
        skip_left = '0;
        if (b == ST_SYSEX) begin
          skip_kind = SKIP_SYSEX;
        end else if (b == ST_TIME_CODE || b == ST_SONG_SELECT) begin
          skip_kind = SKIP_COUNT;
          skip_left = 2'd1;
        end else if (b == ST_SONG_POSITION) begin
          skip_kind = SKIP_COUNT;
          skip_left = 2'd2;
        end
      end
      return;
    end
    if (skip_kind == SKIP_SYSEX) return;
    if (skip_kind == SKIP_COUNT) begin
      if (skip_left != 2'd0) skip_left = skip_left - 2'd1;
      if (skip_left == 2'd0) skip_kind = SKIP_NONE;
      return;
    end
    if (cur_status == 8'd0) return;
    cmd = cur_status[6:4];
    two_bytes = !(cmd == CMD_PROGRAM || cmd == CMD_PRESSURE);
    if (two_bytes && held_count == 2'd0) begin
      held_first = b[6:0];
      held_count = 2'd1;
      return;
    end
    held_count = '0;
    if (two_bytes) complete_message(held_first, b[6:0]);
    else complete_message(b[6:0], 7'd0);
  endfunction

  // ---------------------------------------------------------------------
  // event side: random stalls and the checker
  // ---------------------------------------------------------------------

  // ready low in about a quarter of the cycles, unless in a no-idle stretch
  initial begin
    ev_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      ev_if.ready <= no_idle || ($urandom_range(0, 99) >= 25);
    end
  end

  // every accepted event against the oldest expectation
  always @(posedge clk) begin : check_events
    note_event_t want;
    if (!rst && ev_if.valid && ev_if.ready) begin
      if (pending_events.size() == 0) begin
        report($sformatf("event kind %0d channel %0d with nothing expected",
                         ev_if.event_kind, ev_if.channel));
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", 32'(ev_if.event_kind), 32'(want.kind));
        check_field("channel", 32'(ev_if.channel), 32'(want.channel));
        check_field("key_number", 32'(ev_if.key_number), 32'(want.key_number));
        check_field("pitch", 32'(ev_if.pitch), 32'(want.pitch));
        check_field("velocity", 32'(ev_if.velocity), 32'(want.velocity));
        check_field("event_id", ev_if.event_id, want.event_id);
        check_field("message_code", 32'(ev_if.message_code), 32'(want.message_code));
        check_field("control_number", 32'(ev_if.control_number),
                    32'(want.control_number));
        check_field("control_value", 32'(ev_if.control_value), 32'(want.control_value));
        check_field("instrument", 32'(ev_if.instrument), 32'(want.instrument));
      end
    end
  end

  // ---------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------

  // one midi byte over rx_bytes, random idle cycles in front unless no_idle
  task automatic send_byte(input logic [7:0] b);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 25) begin
        rx_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    rx_if.valid     <= 1'b1;
    rx_if.midi_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    predict_byte(b);
  endtask

  // sender waits for every expected event, up to DRAIN_LIMIT, then settles
  task automatic wait_for_events();
    int waited;
    waited = 0;
    rx_if.valid <= 1'b0;
    while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_events.size() != 0) begin
      report($sformatf("%0d expected events never came", pending_events.size()));
      pending_events.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one apb transfer, setup then access; psel stays up for a following one
  task automatic apb_transfer(input logic [1:0] idx, input bit is_write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // register write while idle, read back, and update the register copy
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rdata;
    logic [31:0] want;
    wait_for_events();
    apb_transfer(idx, 1'b1, value, rdata);
    apb_transfer(idx, 1'b0, 32'd0, rdata);
    apb_release();
    case (idx)
      REG_CHANNEL_MASK: begin
        chan_enable = value[15:0];
        want = {16'd0, chan_enable};
      end
      REG_MESSAGE_MASK: begin
        msg_enable = value[7:0];
        want = {24'd0, msg_enable};
      end
      default: begin
        instr_reg = value[11:0];
        want = {20'd0, instr_reg};
      end
    endcase
    check_field($sformatf("register %0d readback", idx), rdata, want);
  endtask

  task automatic set_filters(input logic [15:0] chans, input logic [7:0] msgs,
                             input logic [11:0] instr);
    write_reg(REG_CHANNEL_MASK, {16'd0, chans});
    write_reg(REG_MESSAGE_MASK, {24'd0, msgs});
    write_reg(REG_INSTRUMENT, {20'd0, instr});
  endtask

  task automatic send_list(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // random traffic: mostly whole channel messages with random content,
  // the rest system common, sysex, broken messages and raw noise
  task automatic send_random(input int count);
    logic [7:0] seq[$];
    logic [2:0] cmd;
    logic [3:0] chn;
    logic [6:0] d1;
    logic [6:0] d2;
    int         pick;
    int         sent;
    sent = 0;
    while (sent < count) begin
      seq.delete();
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        cmd = 3'($urandom_range(0, 6));
        chn = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
        // keys from a small pool half the time so counters climb
        d1 = $urandom_range(0, 1) ? 7'($urandom_range(60, 63)) : 7'($urandom_range(0, 127));
        d2 = ($urandom_range(0, 4) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
        // sometimes lean on running status
        if ($urandom_range(0, 3) != 0) seq.push_back({1'b1, cmd, chn});
        seq.push_back({1'b0, d1});
        if (cmd != CMD_PROGRAM && cmd != CMD_PRESSURE) seq.push_back({1'b0, d2});
        // broken message, last byte lost
        if ($urandom_range(0, 19) == 0) void'(seq.pop_back());
      end else if (pick < 80) begin
        seq.push_back(8'($urandom_range(ST_TIME_CODE, 8'hF7)));
        repeat ($urandom_range(0, 2)) seq.push_back(8'($urandom_range(0, 127)));
      end else if (pick < 85) begin
        seq.push_back(ST_SYSEX);
        repeat ($urandom_range(0, 5)) seq.push_back(8'($urandom_range(0, 127)));
        seq.push_back(($urandom_range(0, 1) == 0) ? 8'hF7 : 8'($urandom_range(8'h80, 8'hF7)));
      end else begin
        seq.push_back(8'($urandom_range(0, 255)));
      end
      foreach (seq[i]) begin
        // real-time bytes can land anywhere, even inside a skip
        if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(ST_REALTIME, 8'hFF)));
        send_byte(seq[i]);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // register values right after reset
  task automatic test_reset_values();
    logic [31:0] rdata;
    apb_transfer(REG_CHANNEL_MASK, 1'b0, 32'd0, rdata);
    check_field("channel mask after reset", rdata, {16'd0, CHANNEL_MASK_RESET});
    apb_transfer(REG_MESSAGE_MASK, 1'b0, 32'd0, rdata);
    check_field("message mask after reset", rdata, {24'd0, MESSAGE_MASK_RESET});
    apb_transfer(REG_INSTRUMENT, 1'b0, 32'd0, rdata);
    check_field("instrument after reset", rdata, 32'd0);
    apb_release();
  endtask

  // field extremes, every message type and the system byte rules
  task automatic test_directed();
    // reset masks: only note off, note on and aftertouch pass
    send_list('{
      8'h45,                    // data byte with no running status
      8'h90, 8'h00, 8'h7F,      // note start, lowest key, top velocity
      8'h7F, 8'h00,             // running status, top key, zero velocity stops
      8'h8F, 8'h3C, 8'hF8, 8'h40, // note off on channel 15, real-time inside
      8'hA3, 8'h10, 8'h20,      // aftertouch, no event
      8'hF0, 8'h01, 8'hF7       // sysex data skipped, end of sysex
    });
    set_filters(16'hFFFF, 8'hFF, 12'hFFF);
    send_list('{
      8'hB2, 8'h07, 8'h64,      // control change
      8'hC5, 8'h7F,             // program change, one data byte
      8'hD1, 8'hF1, 8'h40, 8'h41, // time code skips one byte, then pressure
      8'hE0, 8'hF2, 8'h11, 8'h22, 8'h00, 8'h7F // song position skips two
    });
  endtask

  // channel and message filters, instrument tag, across several settings
  task automatic test_filters();
    set_filters(16'h0000, 8'hFF, 12'h000);
    send_random(60);
    set_filters(16'hFFFF, 8'h00, 12'h800);
    send_random(60);
    set_filters(16'h8001, 8'h48, 12'h123);
    send_random(60);
    repeat (2) begin
      set_filters(16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 8'hFF)),
                  12'($urandom_range(0, 12'hFFF)));
      send_random(60);
    end
    set_filters(16'hFFFF, 8'hFF, 12'($urandom_range(0, 12'hFFF)));
    send_random(80);
    // sender holds until the event side has caught up
    wait_for_events();
    send_random(80);
  endtask

  // start counter of one key past 255, with no idling at all
  task automatic test_counter_wrap();
    logic [3:0] chn;
    logic [6:0] key;
    chn = 4'($urandom_range(0, 15));
    key = 7'($urandom_range(0, 127));
    set_filters(16'hFFFF, 8'h7F, 12'($urandom_range(0, 12'hFFF)));
    no_idle = 1'b1;
    send_byte({1'b1, CMD_NOTE_ON, chn});
    for (int i = 0; i < 260; i++) begin
      send_byte({1'b0, key});
      send_byte(8'($urandom_range(1, 127)));
    end
    no_idle = 1'b0;
  endtask

  // main sequence
  initial begin
    rst             <= 1'b1;
    rx_if.valid     <= 1'b0;
    rx_if.midi_byte <= 8'd0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= 4'd0;
    pwdata          <= 32'd0;
    reset_parser_copy();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_directed();
    test_filters();
    test_counter_wrap();

    wait_for_events();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
